[rtl/jbf_pkg.sv]
package jbf_pkg;

    localparam int unsigned LEVELS_OUT_W = 9;
    localparam int unsigned STATUS_W     = 3;

    typedef enum logic [1:0] {
        REQ_OPEN  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_CLOSE_NO_LEVEL = 3'd1,
        ST_ADD_NO_LEVEL   = 3'd2,
        ST_JOURNAL_FULL   = 3'd3,
        ST_LEVELS_FULL    = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
        logic walk_rd;
        logic walk_wr;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic level_empty;
        logic left_zero;
        logic clr_last;
    } t_stat;

endpackage

[rtl/jbf_ram.sv]
module jbf_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/jbf_ctrl.sv]
module jbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  jbf_pkg::t_stat i_stat,
    output jbf_pkg::t_cmd  o_cmd
);

    import jbf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK_RD,
        S_WALK_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;
    t_cmd   cmd;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.req == REQ_CLOSE && !i_stat.level_empty) begin
                    cmd.exec = 1'b1;
                    n_state  = S_WALK_RD;
                end else if (out_free) begin
                    cmd.exec     = 1'b1;
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK_RD: begin
                if (i_stat.left_zero) begin
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.walk_rd = 1'b1;
                    n_state     = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                cmd.walk_wr = 1'b1;
                n_state     = S_WALK_RD;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not move to execute");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_wr |-> $past(cmd.walk_rd))
        else $error("filter clear issued without a journal read before it");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !cmd.load_out)
        else $error("pending result overwritten");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_WALK_RD))
        else $error("result raised outside a finishing state");

endmodule

[rtl/jbf_datapath.sv]
module jbf_datapath #(
    parameter int unsigned FILTER_BITS   = 8192,
    parameter int unsigned JOURNAL_DEPTH = 1024,
    parameter int unsigned MAX_LEVELS    = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jbf_pkg::t_cmd                       i_cmd,
    output jbf_pkg::t_stat                      o_stat,
    input  logic [1:0]                          i_req_type,
    input  logic [15:0]                         i_hash_value,
    input  logic                                i_query_last,
    output logic                                o_reject,
    output logic                                o_run_done,
    output logic                                o_bit_was_new,
    output logic [jbf_pkg::STATUS_W-1:0]        o_status,
    output logic [jbf_pkg::LEVELS_OUT_W-1:0]    o_levels_open
);

    import jbf_pkg::*;

    localparam int unsigned IW  = $clog2(FILTER_BITS);
    localparam int unsigned JAW = $clog2(JOURNAL_DEPTH);
    localparam int unsigned JFW = $clog2(JOURNAL_DEPTH + 1);
    localparam int unsigned LAW = $clog2(MAX_LEVELS);
    localparam int unsigned LW  = $clog2(MAX_LEVELS + 1);

    // latched request
    t_req             r_req, n_req;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_last, n_last;

    // control state
    logic [IW-1:0]    r_clr_addr, n_clr_addr;
    logic [LW-1:0]    r_level_fill, n_level_fill;
    logic [JFW-1:0]   r_journal_fill, n_journal_fill;
    logic [JFW-1:0]   r_top_count, n_top_count;
    logic [JFW-1:0]   r_close_left, n_close_left;
    logic             r_miss_seen, n_miss_seen;

    // result register
    logic             r_out_reject, n_out_reject;
    logic             r_out_done, n_out_done;
    logic             r_out_new, n_out_new;
    t_status          r_out_status, n_out_status;
    logic [LEVELS_OUT_W-1:0] r_out_levels, n_out_levels;

    logic             res_reject, res_done, res_new, miss;
    t_status          res_status;

    logic             f_we, f_re;
    logic [IW-1:0]    f_waddr, f_raddr;
    logic [0:0]       f_wdata, f_rdata;
    logic             j_we, j_re;
    logic [JAW-1:0]   j_waddr, j_raddr;
    logic [IW-1:0]    j_wdata, j_rdata;
    logic             l_we, l_re;
    logic [LAW-1:0]   l_waddr, l_raddr;
    logic [JFW-1:0]   l_wdata, l_rdata;

    logic [LW-1:0]    lf_dec, lf_dec2;
    logic [JFW-1:0]   jf_dec;

    assign lf_dec  = r_level_fill - LW'(1);
    assign lf_dec2 = r_level_fill - LW'(2);
    assign jf_dec  = r_journal_fill - JFW'(1);

    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_idx;
        f_wdata = 1'b0;
        f_re    = 1'b0;
        f_raddr = i_hash_value[IW-1:0];
        j_we    = 1'b0;
        j_waddr = r_journal_fill[JAW-1:0];
        j_wdata = r_idx;
        j_re    = 1'b0;
        j_raddr = jf_dec[JAW-1:0];
        l_we    = 1'b0;
        l_waddr = lf_dec[LAW-1:0];
        l_wdata = r_top_count;
        l_re    = 1'b0;
        l_raddr = lf_dec2[LAW-1:0];

        n_req          = r_req;
        n_idx          = r_idx;
        n_last         = r_last;
        n_clr_addr     = r_clr_addr;
        n_level_fill   = r_level_fill;
        n_journal_fill = r_journal_fill;
        n_top_count    = r_top_count;
        n_close_left   = r_close_left;
        n_miss_seen    = r_miss_seen;

        res_reject = 1'b0;
        res_done   = 1'b0;
        res_new    = 1'b0;
        res_status = ST_OK;
        miss       = r_miss_seen | ~f_rdata[0];

        if (i_cmd.clear_step) begin
            f_we       = 1'b1;
            f_waddr    = r_clr_addr;
            n_clr_addr = r_clr_addr + IW'(1);
        end

        // bit lookup and the count of the level below the top start at transfer
        if (i_cmd.accept) begin
            f_re   = 1'b1;
            l_re   = 1'b1;
            n_req  = t_req'(i_req_type);
            n_idx  = i_hash_value[IW-1:0];
            n_last = i_query_last;
        end

        if (i_cmd.exec) begin
            case (r_req)
                REQ_OPEN: begin
                    if (r_level_fill == LW'(MAX_LEVELS)) begin
                        res_status = ST_LEVELS_FULL;
                    end else begin
                        // spill the current top count below the new level
                        l_we         = (r_level_fill != '0);
                        n_top_count  = '0;
                        n_level_fill = r_level_fill + LW'(1);
                    end
                end
                REQ_ADD: begin
                    if (r_level_fill == '0) begin
                        res_status = ST_ADD_NO_LEVEL;
                    end else if (!f_rdata[0]) begin
                        res_new = 1'b1;
                        f_we    = 1'b1;
                        f_wdata = 1'b1;
                        if (r_journal_fill < JFW'(JOURNAL_DEPTH)) begin
                            j_we           = 1'b1;
                            n_journal_fill = r_journal_fill + JFW'(1);
                            n_top_count    = r_top_count + JFW'(1);
                        end else begin
                            res_status = ST_JOURNAL_FULL;
                        end
                    end
                end
                REQ_CLOSE: begin
                    if (r_level_fill == '0) begin
                        res_status = ST_CLOSE_NO_LEVEL;
                    end else begin
                        n_level_fill = lf_dec;
                        n_close_left = (r_top_count > r_journal_fill) ?
                                       r_journal_fill : r_top_count;
                        n_top_count  = (r_level_fill > LW'(1)) ? l_rdata : '0;
                    end
                end
                REQ_QUERY: begin
                    res_reject  = miss;
                    res_done    = r_last;
                    n_miss_seen = r_last ? 1'b0 : miss;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.walk_rd) begin
            j_re           = 1'b1;
            n_journal_fill = jf_dec;
            n_close_left   = r_close_left - JFW'(1);
        end

        if (i_cmd.walk_wr) begin
            f_we    = 1'b1;
            f_waddr = j_rdata;
        end

        n_out_reject = r_out_reject;
        n_out_done   = r_out_done;
        n_out_new    = r_out_new;
        n_out_status = r_out_status;
        n_out_levels = r_out_levels;
        if (i_cmd.load_out) begin
            n_out_reject = res_reject;
            n_out_done   = res_done;
            n_out_new    = res_new;
            n_out_status = res_status;
            n_out_levels = LEVELS_OUT_W'(n_level_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr     <= '0;
            r_level_fill   <= '0;
            r_journal_fill <= '0;
            r_top_count    <= '0;
            r_miss_seen    <= 1'b0;
        end else begin
            r_clr_addr     <= n_clr_addr;
            r_level_fill   <= n_level_fill;
            r_journal_fill <= n_journal_fill;
            r_top_count    <= n_top_count;
            r_miss_seen    <= n_miss_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_close_left <= n_close_left;
        r_out_reject <= n_out_reject;
        r_out_done   <= n_out_done;
        r_out_new    <= n_out_new;
        r_out_status <= n_out_status;
        r_out_levels <= n_out_levels;
    end

    jbf_ram #(
        .WIDTH (1),
        .DEPTH (FILTER_BITS)
    ) u_filter_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    jbf_ram #(
        .WIDTH (IW),
        .DEPTH (JOURNAL_DEPTH)
    ) u_journal_ram (
        .i_clk   (i_clk),
        .i_we    (j_we),
        .i_waddr (j_waddr),
        .i_wdata (j_wdata),
        .i_re    (j_re),
        .i_raddr (j_raddr),
        .o_rdata (j_rdata)
    );

    jbf_ram #(
        .WIDTH (JFW),
        .DEPTH (MAX_LEVELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign o_stat.req         = r_req;
    assign o_stat.level_empty = (r_level_fill == '0);
    assign o_stat.left_zero   = (r_close_left == '0);
    assign o_stat.clr_last    = &r_clr_addr;

    assign o_reject      = r_out_reject;
    assign o_run_done    = r_out_done;
    assign o_bit_was_new = r_out_new;
    assign o_status      = r_out_status;
    assign o_levels_open = r_out_levels;

    a_journal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_journal_fill <= JFW'(JOURNAL_DEPTH))
        else $error("journal fill beyond depth");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_fill <= LW'(MAX_LEVELS))
        else $error("level stack beyond capacity");

    a_top_within_journal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level_fill != '0) |-> (r_top_count <= r_journal_fill))
        else $error("top level count exceeds journal fill");

endmodule

[rtl/journaled_bloom_filter_top.sv]
// Journaled Bloom filter over 16-bit ancestor hashes. Open pushes a level, add sets the
// bit at hash_value mod FILTER_BITS and journals it when it was clear, close clears the
// bits the innermost level turned on, and query runs report reject once any hash of the
// run hits a clear bit. Each transfer in gives exactly one result out. After reset the
// bit memory is swept clear, one entry per cycle, before the first request is taken.
// Open, add, query and a refused close read the bit memory when the request is taken,
// then update it and register the result once the result register is free. A close
// with a level instead walks the entries that level journaled: each journal entry needs
// a read of the journal memory followed by a write of the bit memory. One request is in
// work at a time; the result register lets the next request in while a result waits.
module journaled_bloom_filter_top #(
    parameter int unsigned FILTER_BITS   = 8192,
    parameter int unsigned JOURNAL_DEPTH = 1024,
    parameter int unsigned MAX_LEVELS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_hash_value,
    input  logic        i_query_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reject,
    output logic        o_run_done,
    output logic        o_bit_was_new,
    output logic [2:0]  o_status,
    output logic [8:0]  o_levels_open
);

    import jbf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    jbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jbf_datapath #(
        .FILTER_BITS   (FILTER_BITS),
        .JOURNAL_DEPTH (JOURNAL_DEPTH),
        .MAX_LEVELS    (MAX_LEVELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_hash_value  (i_hash_value),
        .i_query_last  (i_query_last),
        .o_reject      (o_reject),
        .o_run_done    (o_run_done),
        .o_bit_was_new (o_bit_was_new),
        .o_status      (o_status),
        .o_levels_open (o_levels_open)
    );

endmodule
